// ===== src/bct_pkg.sv =====
// ----------------------------------------------------------------------------
// Buffer cache tag store package
// Sizes, entry layout, request kinds and status codes for the tag store;
// the entry memory is sized from them through its parameters.
// ----------------------------------------------------------------------------
package bct_pkg;

   localparam int ENTRIES    = 32;
   localparam int COUNT_BITS = 8;
   localparam int IDX_W      = $clog2(ENTRIES);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic [15:0]           device;
      logic [31:0]           block;
      logic [COUNT_BITS-1:0] count;
      logic [31:0]           rtime;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [1:0] {
      KIND_GET     = 2'd0,
      KIND_RELEASE = 2'd1,
      KIND_PIN     = 2'd2,
      KIND_UNPIN   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NO_FREE   = 2'd1,
      ST_UNDERFLOW = 2'd2,
      ST_OVERFLOW  = 2'd3
   } status_type;

endpackage

// ===== src/bct_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module bct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/block_buffer_cache_tags.sv =====
// Results: a get returns its result after a scan of all ENTRIES entries;
//   release, pin and unpin return theirs from the addressed entry, with no scan.
// Flow: a new request is taken only in the idle state; the entry memory scan
//   paces a get. A result held in the output register stalls the next update, and a
//   new request is taken while it waits.
// Reset: synchronous, clears control state, valid and written flags;
//   unwritten entries read as all zero, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// Buffer cache tag store
// Looks up, allocates and reference-counts block cache entries with one
// shared compare unit scanning the entry memory.
// ----------------------------------------------------------------------------
module block_buffer_cache_tags (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [15:0] req_device,
   input  logic [31:0] req_block_number,
   input  logic [4:0]  req_entry_index,
   input  logic [31:0] req_now_tick,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_result_index,
   output logic        rsp_need_read,
   output logic        rsp_hit,
   output logic [1:0]  rsp_status
);

   import bct_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_SCAN = 4'b0010,
      S_GFIN = 4'b0100,
      S_OP   = 4'b1000
   } state_type;

   localparam logic [IDX_W:0]   SCAN_END = (IDX_W + 1)'(ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   state_type             state_ff, state_in;
   logic [1:0]            kind_ff, kind_in;
   logic [15:0]           dev_ff, dev_in;
   logic [31:0]           blk_ff, blk_in;
   logic [4:0]            idx_ff, idx_in;
   logic [31:0]           now_ff, now_in;
   logic [IDX_W:0]        scan_ff, scan_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]      rd_idx_ff, rd_idx_in;
   logic                  mfound_ff, mfound_in;
   logic [IDX_W-1:0]      midx_ff, midx_in;
   entry_type             mword_ff, mword_in;
   logic                  ffound_ff, ffound_in;
   logic [IDX_W-1:0]      fidx_ff, fidx_in;
   entry_type             fword_ff, fword_in;
   logic [ENTRIES-1:0]    written_ff, written_in;
   logic [ENTRIES-1:0]    evalid_ff, evalid_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [4:0]            rsp_index_ff, rsp_index_in;
   logic                  rsp_read_ff, rsp_read_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   status_type            rsp_status_ff, rsp_status_in;

   logic                  ram_we;
   logic [IDX_W-1:0]      ram_waddr;
   entry_type             ram_wdata;
   logic [IDX_W-1:0]      ram_raddr;
   logic [ENTRY_W-1:0]    ram_rdata;

   logic [IDX_W-1:0]      cur_idx;
   entry_type             cur_word;
   logic [IDX_W-1:0]      op_addr;
   logic                  op_in_range;
   logic                  out_free;
   logic                  accept;
   logic                  is_match;
   logic                  older_free;

   bct_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (ENTRIES)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign req_ready   = (state_ff == S_IDLE);
   assign accept      = req_valid && req_ready;
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign op_addr     = IDX_W'(idx_ff);
   assign op_in_range = 32'(idx_ff) < 32'(ENTRIES);
   assign cur_idx     = (state_ff == S_OP) ? op_addr : rd_idx_ff;
   assign cur_word    = written_ff[cur_idx] ? entry_type'(ram_rdata) : '0;
   assign is_match    = (cur_word.device == dev_ff) && (cur_word.block == blk_ff);
   assign older_free  = (cur_word.count == '0) &&
                        (!ffound_ff || (cur_word.rtime < fword_ff.rtime));

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      dev_in        = dev_ff;
      blk_in        = blk_ff;
      idx_in        = idx_ff;
      now_in        = now_ff;
      scan_in       = scan_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = rd_idx_ff;
      mfound_in     = mfound_ff;
      midx_in       = midx_ff;
      mword_in      = mword_ff;
      ffound_in     = ffound_ff;
      fidx_in       = fidx_ff;
      fword_in      = fword_ff;
      written_in    = written_ff;
      evalid_in     = evalid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_index_in  = rsp_index_ff;
      rsp_read_in   = rsp_read_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_status_in = rsp_status_ff;
      ram_we        = 1'b0;
      ram_waddr     = cur_idx;
      ram_wdata     = cur_word;
      ram_raddr     = IDX_W'(req_entry_index);

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               kind_in   = req_kind;
               dev_in    = req_device;
               blk_in    = req_block_number;
               idx_in    = req_entry_index;
               now_in    = req_now_tick;
               scan_in   = '0;
               mfound_in = 1'b0;
               ffound_in = 1'b0;
               state_in  = (kind_type'(req_kind) == KIND_GET) ? S_SCAN : S_OP;
            end
         end

         S_SCAN: begin
            ram_raddr = scan_ff[IDX_W-1:0];
            if (scan_ff != SCAN_END) begin
               rd_vld_in = 1'b1;
               rd_idx_in = scan_ff[IDX_W-1:0];
               scan_in   = scan_ff + 1'b1;
            end
            if (rd_vld_ff) begin
               if (is_match && !mfound_ff) begin
                  mfound_in = 1'b1;
                  midx_in   = rd_idx_ff;
                  mword_in  = cur_word;
               end
               if (older_free) begin
                  ffound_in = 1'b1;
                  fidx_in   = rd_idx_ff;
                  fword_in  = cur_word;
               end
               if (rd_idx_ff == LAST_IDX) begin
                  state_in = S_GFIN;
               end
            end
         end

         S_GFIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (mfound_ff) begin
                  rsp_index_in = 5'(midx_ff);
                  rsp_hit_in   = 1'b1;
                  if (mword_ff.count == COUNT_MAX) begin
                     rsp_read_in   = 1'b0;
                     rsp_status_in = ST_OVERFLOW;
                  end else begin
                     rsp_read_in     = !evalid_ff[midx_ff];
                     rsp_status_in   = ST_OK;
                     ram_we          = 1'b1;
                     ram_waddr       = midx_ff;
                     ram_wdata       = mword_ff;
                     ram_wdata.count = mword_ff.count + 1'b1;
                     written_in[midx_ff] = 1'b1;
                     evalid_in[midx_ff]  = 1'b1;
                  end
               end else if (ffound_ff) begin
                  rsp_index_in     = 5'(fidx_ff);
                  rsp_hit_in       = 1'b0;
                  rsp_read_in      = 1'b1;
                  rsp_status_in    = ST_OK;
                  ram_we           = 1'b1;
                  ram_waddr        = fidx_ff;
                  ram_wdata.device = dev_ff;
                  ram_wdata.block  = blk_ff;
                  ram_wdata.count  = COUNT_BITS'(1);
                  ram_wdata.rtime  = fword_ff.rtime;
                  written_in[fidx_ff] = 1'b1;
                  evalid_in[fidx_ff]  = 1'b1;
               end else begin
                  rsp_index_in  = '0;
                  rsp_hit_in    = 1'b0;
                  rsp_read_in   = 1'b0;
                  rsp_status_in = ST_NO_FREE;
               end
            end
         end

         S_OP: begin
            ram_raddr = op_addr;
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_index_in  = idx_ff;
               rsp_hit_in    = 1'b0;
               rsp_read_in   = 1'b0;
               rsp_status_in = ST_OK;
               state_in      = S_IDLE;
               ram_waddr     = op_addr;
               if (op_in_range) begin
                  if (kind_type'(kind_ff) == KIND_PIN) begin
                     if (cur_word.count == COUNT_MAX) begin
                        rsp_status_in = ST_OVERFLOW;
                     end else begin
                        ram_we          = 1'b1;
                        ram_wdata.count = cur_word.count + 1'b1;
                     end
                  end else if (cur_word.count == '0) begin
                     rsp_status_in = ST_UNDERFLOW;
                  end else begin
                     ram_we          = 1'b1;
                     ram_wdata.count = cur_word.count - 1'b1;
                     if ((kind_type'(kind_ff) == KIND_RELEASE) &&
                         (cur_word.count == COUNT_BITS'(1))) begin
                        ram_wdata.rtime = now_ff;
                     end
                  end
                  if (ram_we) begin
                     written_in[op_addr] = 1'b1;
                  end
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rd_vld_ff    <= 1'b0;
         written_ff   <= '0;
         evalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= rd_vld_in;
         written_ff   <= written_in;
         evalid_ff    <= evalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      dev_ff        <= dev_in;
      blk_ff        <= blk_in;
      idx_ff        <= idx_in;
      now_ff        <= now_in;
      scan_ff       <= scan_in;
      rd_idx_ff     <= rd_idx_in;
      mfound_ff     <= mfound_in;
      midx_ff       <= midx_in;
      mword_ff      <= mword_in;
      ffound_ff     <= ffound_in;
      fidx_ff       <= fidx_in;
      fword_ff      <= fword_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_read_ff   <= rsp_read_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_index = rsp_index_ff;
   assign rsp_need_read    = rsp_read_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_status       = rsp_status_ff;

`ifndef ASSERT_OFF
   a_we_in_update: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_GFIN || state_ff == S_OP))
      else $error("entry write outside update state");

   a_result_from_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_GFIN || state_ff == S_OP))
      else $error("result raised without an update");

   a_no_free_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_NO_FREE) |->
         (!rsp_hit_ff && !rsp_read_ff && rsp_index_ff == '0))
      else $error("no-free result carries entry data");

   a_read_only_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_read_ff) |-> (rsp_status_ff == ST_OK))
      else $error("disk read flagged on an error");

   a_scan_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && rd_vld_ff && rd_idx_ff == LAST_IDX) |=> (state_ff == S_GFIN))
      else $error("scan end did not reach allocation");
`endif

endmodule
